FILE: sv/cfdm_pkg.sv
// Shared constants and types for the capture frequency and duty meter.
package cfdm_pkg;

  // Field and register widths
  localparam int CAPTURE_WIDTH   = 16;
  localparam int VALUE_WIDTH     = 16;
  localparam int CLOCK_HZ_WIDTH  = 27;
  localparam int PRESCALER_WIDTH = 11;
  localparam int CFG_INDEX_WIDTH = 2;

  // Default timer width
  localparam int TIME_WIDTH_DEFAULT = 16;

  // Percent scale and the bits it needs as a multiplier operand
  localparam int PERCENT       = 100;
  localparam int PERCENT_WIDTH = 7;

  // Result saturation limit
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = 16'hFFFF;

  // Register reset values
  localparam logic                       MODE_RESET      = 1'b0;
  localparam logic [CLOCK_HZ_WIDTH-1:0]  CLOCK_HZ_RESET  = 27'd8000000;
  localparam logic [PRESCALER_WIDTH-1:0] PRESCALER_RESET = 11'd1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_MEASURE_MODE = 2'd0,
    CFG_CLOCK_HZ     = 2'd1,
    CFG_PRESCALER    = 2'd2
  } cfg_index_t;

  // Measurement modes
  localparam logic MODE_FREQUENCY = 1'b0;
  localparam logic MODE_DUTY      = 1'b1;

  // Capture actions
  localparam logic ACTION_START   = 1'b0;
  localparam logic ACTION_CAPTURE = 1'b1;

endpackage

FILE: sv/capture_frequency_duty_meter.sv
// Top level of the capture frequency and duty meter.
// Timer capture transactions drive a small edge sequencer. A start transaction or an edge
// that does not close a measurement is accepted while the sequencer is idle and gives no
// result. An edge that closes a measurement with bad timestamps goes straight to S_LOAD
// and gives a failed result. A valid closing edge runs a multiply step and then a restoring
// divider that yields one quotient bit per cycle; item_stall stays high while it runs and
// until S_LOAD has handed the result on to a free output slot. Frequency
// mode gives clock_hz / (period * prescaler) saturated at 65535, with a prescaler of zero
// taken as one; duty mode gives on_time * 100 / period. Only the low TIME_WIDTH bits of
// capture_time are used. After each result the sequence waits for a new first rising edge.
module capture_frequency_duty_meter #(
  parameter int TIME_WIDTH = cfdm_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cfdm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [cfdm_pkg::CLOCK_HZ_WIDTH-1:0]   cfg_data,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  action,
  input  logic                                  edge_rising,
  input  logic [cfdm_pkg::CAPTURE_WIDTH-1:0]    capture_time,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [cfdm_pkg::VALUE_WIDTH-1:0]      measured_value,
  output logic                                  measure_failed
);

  localparam int CW   = cfdm_pkg::CAPTURE_WIDTH;
  localparam int PW   = cfdm_pkg::PRESCALER_WIDTH;
  localparam int KEEP = (TIME_WIDTH < CW) ? TIME_WIDTH : CW;
  localparam logic [CW-1:0] CAP_MASK = CW'((33'd1 << KEEP) - 33'd1);
  localparam int MW = TIME_WIDTH + PW;
  localparam int DW = (TIME_WIDTH + cfdm_pkg::PERCENT_WIDTH > cfdm_pkg::CLOCK_HZ_WIDTH) ?
                      TIME_WIDTH + cfdm_pkg::PERCENT_WIDTH : cfdm_pkg::CLOCK_HZ_WIDTH;

  typedef enum logic [1:0] {
    PH_FIRST_RISE  = 2'd0,
    PH_SECOND_EDGE = 2'd1,
    PH_CLOSE_RISE  = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SEED = 5'b00100,
    S_DIV  = 5'b01000,
    S_LOAD = 5'b10000
  } state_t;

  // Configuration registers
  logic                                 measure_mode;
  logic [cfdm_pkg::CLOCK_HZ_WIDTH-1:0]  clock_hz;
  logic [PW-1:0]                        prescaler;

  // Sequence state
  state_t                  state;
  phase_t                  phase;
  logic [TIME_WIDTH-1:0]   first_rise_time;
  logic [TIME_WIDTH-1:0]   first_fall_time;

  // Operands and intermediate results
  logic                    op_duty;
  logic [TIME_WIDTH-1:0]   op_a;
  logic [PW-1:0]           op_b;
  logic [TIME_WIDTH-1:0]   op_period;
  logic [MW-1:0]           product;
  logic [cfdm_pkg::VALUE_WIDTH-1:0] pend_value;
  logic                    pend_failed;

  // Divider hookup
  logic                    div_start;
  logic                    div_done;
  logic [DW-1:0]           div_dividend;
  logic [MW-1:0]           div_divisor;
  logic [DW-1:0]           div_quotient;
  logic [cfdm_pkg::VALUE_WIDTH-1:0] sat_value;

  // Decode of the current transaction
  logic                    accept;
  logic [TIME_WIDTH-1:0]   t_now;
  logic                    fin_freq;
  logic                    fin_duty;
  logic                    take_rise;
  logic                    take_fall;
  logic                    freq_bad;
  logic                    duty_bad;
  logic [PW-1:0]           div_scale;
  logic                    slot_free;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign t_now      = TIME_WIDTH'(capture_time & CAP_MASK);
  assign freq_bad   = !(t_now > first_rise_time);
  assign duty_bad   = !((first_fall_time > first_rise_time) && (t_now > first_fall_time));
  assign div_scale  = (prescaler == '0) ? PW'(1) : prescaler;
  assign slot_free  = !result_valid || !result_stall;

  // Classify a capture edge against the phase and mode
  always_comb begin
    fin_freq  = 1'b0;
    fin_duty  = 1'b0;
    take_rise = 1'b0;
    take_fall = 1'b0;
    case (phase)
      PH_SECOND_EDGE, PH_CLOSE_RISE: begin
        if (measure_mode == cfdm_pkg::MODE_FREQUENCY) begin
          fin_freq = edge_rising;
        end else if (phase == PH_SECOND_EDGE) begin
          take_fall = !edge_rising;
        end else begin
          fin_duty = edge_rising;
        end
      end
      default: begin
        take_rise = edge_rising;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_mode <= cfdm_pkg::MODE_RESET;
      clock_hz     <= cfdm_pkg::CLOCK_HZ_RESET;
      prescaler    <= cfdm_pkg::PRESCALER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cfdm_pkg::CFG_MEASURE_MODE: measure_mode <= cfg_data[0];
        cfdm_pkg::CFG_CLOCK_HZ:     clock_hz     <= cfg_data;
        cfdm_pkg::CFG_PRESCALER:    prescaler    <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the edge sequence on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST_RISE;
      first_rise_time <= '0;
      first_fall_time <= '0;
    end else if (accept) begin
      if (action == cfdm_pkg::ACTION_START) begin
        phase           <= PH_FIRST_RISE;
        first_rise_time <= '0;
        first_fall_time <= '0;
      end else if (fin_freq || fin_duty) begin
        phase <= PH_FIRST_RISE;
      end else if (take_fall) begin
        first_fall_time <= t_now;
        phase           <= PH_CLOSE_RISE;
      end else if (take_rise) begin
        first_rise_time <= t_now;
        phase           <= PH_SECOND_EDGE;
      end
    end
  end

  // Sequencer for the multiply and divide of a closing edge
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && action == cfdm_pkg::ACTION_CAPTURE) begin
            if ((fin_freq && freq_bad) || (fin_duty && duty_bad)) begin
              state <= S_LOAD;
            end else if (fin_freq || fin_duty) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL:  state <= S_SEED;
        S_SEED: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch operands and hold intermediate results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      op_duty   <= fin_duty;
      op_period <= t_now - first_rise_time;
      if (fin_duty) begin
        op_a <= first_fall_time - first_rise_time;
        op_b <= PW'(cfdm_pkg::PERCENT);
      end else begin
        op_a <= t_now - first_rise_time;
        op_b <= div_scale;
      end
      pend_value  <= '0;
      pend_failed <= 1'b1;
    end
    if (state == S_MUL) begin
      product <= MW'(op_a) * MW'(op_b);
    end
    if (state == S_DIV && div_done) begin
      pend_value  <= sat_value;
      pend_failed <= 1'b0;
    end
  end

  // Pick dividend and divisor for the mode
  assign div_start    = (state == S_SEED);
  assign div_dividend = op_duty ? DW'(product) : DW'(clock_hz);
  assign div_divisor  = op_duty ? MW'(op_period) : product;
  assign sat_value    = (div_quotient > DW'(cfdm_pkg::VALUE_MAX)) ?
                        cfdm_pkg::VALUE_MAX : div_quotient[cfdm_pkg::VALUE_WIDTH-1:0];

  cfdm_divider #(
    .DIVIDEND_WIDTH (DW),
    .DIVISOR_WIDTH  (MW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Output register: load when the slot is free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_LOAD && slot_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && slot_free) begin
      measured_value <= pend_value;
      measure_failed <= pend_failed;
    end
  end

endmodule

FILE: sv/cfdm_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module cfdm_divider #(
  parameter int DIVIDEND_WIDTH = 27,
  parameter int DIVISOR_WIDTH  = 27
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVIDEND_WIDTH-1:0] dividend,
  input  logic [DIVISOR_WIDTH-1:0]  divisor,
  output logic                      done,
  output logic [DIVIDEND_WIDTH-1:0] quotient
);

  localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);
  localparam logic [CNT_WIDTH-1:0] LAST_COUNT = CNT_WIDTH'(DIVIDEND_WIDTH);

  logic                     busy;
  logic [CNT_WIDTH-1:0]     count;
  logic [DIVISOR_WIDTH-1:0] rem;
  logic [DIVISOR_WIDTH-1:0] div_q;
  logic [DIVISOR_WIDTH:0]   trial;
  logic                     take;

  // Shift the next dividend bit into the partial remainder and compare
  assign trial = {rem, quotient[DIVIDEND_WIDTH-1]};
  assign take  = (trial >= {1'b0, div_q});
  assign done  = busy && (count == LAST_COUNT);

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      count <= count + CNT_WIDTH'(1);
    end
  end

  // Datapath: load operands, then one subtract-and-shift step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div_q    <= divisor;
      quotient <= dividend;
    end else if (busy && !done) begin
      if (take) begin
        rem <= DIVISOR_WIDTH'(trial - {1'b0, div_q});
      end else begin
        rem <= trial[DIVISOR_WIDTH-1:0];
      end
      quotient <= {quotient[DIVIDEND_WIDTH-2:0], take};
    end
  end

endmodule

FILE: sv/cfdm_checker.sv
// Port-level checks for the capture frequency and duty meter, bound to the top level.
module cfdm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              item_stall,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic [cfdm_pkg::VALUE_WIDTH-1:0]  measured_value,
  input logic                              measure_failed
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(measured_value)
                                     && $stable(measure_failed))
    else $error("stalled result changed");

  // A failed measurement reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && measure_failed |-> measured_value == '0)
    else $error("failed result with nonzero value");

  // A new result only comes out of a busy sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without a busy sequence");

  // Reset empties the output and frees the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("state not cleared by reset");

endmodule

bind capture_frequency_duty_meter cfdm_checker u_cfdm_checker (
  .clk            (clk),
  .rst            (rst),
  .item_stall     (item_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .measured_value (measured_value),
  .measure_failed (measure_failed)
);

FILE: dv/meter_checker.sv
// Checker that predicts meter readings from the item channel and compares them with the results.
`timescale 1ns / 100ps

module meter_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [cfdm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [cfdm_pkg::CLOCK_HZ_WIDTH-1:0]  cfg_data,
  input  logic                                 item_valid,
  input  logic                                 item_stall,
  input  logic                                 action,
  input  logic                                 edge_rising,
  input  logic [cfdm_pkg::CAPTURE_WIDTH-1:0]   capture_time,
  input  logic                                 result_valid,
  input  logic                                 result_stall,
  input  logic [cfdm_pkg::VALUE_WIDTH-1:0]     measured_value,
  input  logic                                 measure_failed,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   readings_checked
);
  import cfdm_pkg::*;

  typedef enum logic [1:0] {
    WAIT_FIRST_RISE   = 2'd0,
    WAIT_SECOND_EDGE  = 2'd1,
    WAIT_CLOSING_RISE = 2'd2,
    PHASE_SPARE       = 2'd3
  } seq_phase_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   failed;
  } reading_t;

  // Shadow registers and sequencer state
  logic                       mode_q;
  logic [CLOCK_HZ_WIDTH-1:0]  clock_hz_q;
  logic [PRESCALER_WIDTH-1:0] prescaler_q;
  seq_phase_t                 phase_q;
  logic [CAPTURE_WIDTH-1:0]   rise_q;
  logic [CAPTURE_WIDTH-1:0]   fall_q;

  reading_t expected_readings[$];

  // Advance the edge sequencer by one transaction; return 1 when a reading comes out
  function automatic bit predict_reading(input logic act, input logic rising,
                                         input logic [CAPTURE_WIDTH-1:0] t,
                                         output reading_t res);
    longint unsigned period;
    longint unsigned on_time;
    longint unsigned divisor;
    longint unsigned quotient;
    bit closes;
    closes = 1'b0;
    res = '0;
    if (act == ACTION_START) begin
      phase_q = WAIT_FIRST_RISE;
      rise_q = '0;
      fall_q = '0;
    end else begin
      case (phase_q)
        WAIT_SECOND_EDGE, WAIT_CLOSING_RISE: begin
          if (mode_q == MODE_FREQUENCY) begin
            // Frequency mode takes any rising edge here as the second one
            if (rising) begin
              closes = 1'b1;
              if (t <= rise_q) begin
                res.failed = 1'b1;
              end else begin
                period = longint'(t) - longint'(rise_q);
                divisor = (prescaler_q == '0) ? 1 : longint'(prescaler_q);
                quotient = longint'(clock_hz_q) / (period * divisor);
                res.value = (quotient > VALUE_MAX) ? VALUE_MAX : quotient[VALUE_WIDTH-1:0];
              end
            end
          end else if (phase_q == WAIT_SECOND_EDGE) begin
            if (!rising) begin
              fall_q = t;
              phase_q = WAIT_CLOSING_RISE;
            end
          end else if (rising) begin
            closes = 1'b1;
            if (fall_q > rise_q && t > fall_q) begin
              period = longint'(t) - longint'(rise_q);
              on_time = longint'(fall_q) - longint'(rise_q);
              quotient = (on_time * PERCENT) / period;
              res.value = quotient[VALUE_WIDTH-1:0];
            end else begin
              res.failed = 1'b1;
            end
          end
        end
        default: begin
          if (rising) begin
            rise_q = t;
            phase_q = WAIT_SECOND_EDGE;
          end
        end
      endcase
      if (closes) phase_q = WAIT_FIRST_RISE;
    end
    return closes;
  endfunction

  // Track register writes, predict on item transactions, compare on result transactions
  always @(posedge clk) begin
    reading_t fresh;
    reading_t want;
    if (rst) begin
      mode_q = MODE_RESET;
      clock_hz_q = CLOCK_HZ_RESET;
      prescaler_q = PRESCALER_RESET;
      phase_q = WAIT_FIRST_RISE;
      rise_q = '0;
      fall_q = '0;
      expected_readings.delete();
      mismatches = 0;
      readings_checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index_t'(cfg_index))
          CFG_MEASURE_MODE: mode_q = cfg_data[0];
          CFG_CLOCK_HZ:     clock_hz_q = cfg_data;
          CFG_PRESCALER:    prescaler_q = cfg_data[PRESCALER_WIDTH-1:0];
          default: ;
        endcase
      end

      // Drain first so a result never matches the item taken at the same edge
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          $display("%0t: reading with none expected, actual value %0d failed %0b",
                   $time, measured_value, measure_failed);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (measured_value !== want.value) begin
            mismatches++;
            $display("%0t: measured_value expected %0d actual %0d",
                     $time, want.value, measured_value);
          end
          if (measure_failed !== want.failed) begin
            mismatches++;
            $display("%0t: measure_failed expected %0b actual %0b",
                     $time, want.failed, measure_failed);
          end
        end
      end

      if (item_valid && !item_stall) begin
        if (predict_reading(action, edge_rising, capture_time, fresh))
          expected_readings.push_back(fresh);
      end
    end
    pending = expected_readings.size();
  end

endmodule

FILE: dv/tb_top.sv
// Top of the meter testbench: clock, reset, register setup, capture stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import cfdm_pkg::*;

  localparam logic EDGE_RISE    = 1'b1;
  localparam logic EDGE_FALL    = 1'b0;
  localparam int   IDLE_CYCLES  = 48;
  localparam int   PHASE_ITEMS  = 215;
  localparam int   PHASE_COUNT  = 8;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CLOCK_HZ_WIDTH-1:0]  cfg_data = '0;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic                       action = ACTION_START;
  logic                       edge_rising = EDGE_FALL;
  logic [CAPTURE_WIDTH-1:0]   capture_time = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [VALUE_WIDTH-1:0]     measured_value;
  logic                       measure_failed;

  int   mismatches;
  int   pending;
  int   readings_checked;
  bit   quiet = 1'b0;
  logic cur_mode = MODE_RESET;
  int   items_sent = 0;
  int   settings_used = 1;
  int   stall_left = 0;

  always #5 clk = ~clk;

  capture_frequency_duty_meter uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .edge_rising    (edge_rising),
    .capture_time   (capture_time),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .measured_value (measured_value),
    .measure_failed (measure_failed)
  );

  meter_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .action           (action),
    .edge_rising      (edge_rising),
    .capture_time     (capture_time),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .measured_value   (measured_value),
    .measure_failed   (measure_failed),
    .mismatches       (mismatches),
    .pending          (pending),
    .readings_checked (readings_checked)
  );

  // Hold off the result channel in random bursts, except in reset or a quiet phase
  always @(posedge clk) begin
    if (rst || quiet) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Present one capture transaction, maybe after an idle burst, and wait for it to be taken
  task automatic send_item(input logic act, input logic rising, input int t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    edge_rising <= rising;
    capture_time <= t[CAPTURE_WIDTH-1:0];
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // Drop valid, drain every expected reading, then let the divider run out
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CLOCK_HZ_WIDTH-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setting(input logic mode, input int hz, input int presc);
    settle();
    write_reg(CFG_MEASURE_MODE, CLOCK_HZ_WIDTH'(mode));
    write_reg(CFG_CLOCK_HZ, hz[CLOCK_HZ_WIDTH-1:0]);
    write_reg(CFG_PRESCALER, presc[CLOCK_HZ_WIDTH-1:0]);
    cur_mode = mode;
    settings_used++;
  endtask

  // Mostly well-formed edge sequences, the rest broken timestamps, restarts and noise
  task automatic run_sequence();
    int kind;
    int cls;
    int span;
    int t0;
    int on_time;
    kind = $urandom_range(0, 9);
    cls = $urandom_range(0, 2);
    span = (cls == 0) ? $urandom_range(2, 64) :
           (cls == 1) ? $urandom_range(2, 1024) : $urandom_range(2, 65535);
    t0 = $urandom_range(0, 65535 - span);
    on_time = $urandom_range(1, span - 1);
    if (kind <= 6) begin
      if ($urandom_range(0, 3) == 0)
        send_item(ACTION_START, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      send_item(ACTION_CAPTURE, EDGE_RISE, t0);
      if (cur_mode == MODE_FREQUENCY) begin
        if ($urandom_range(0, 3) == 0)
          send_item(ACTION_CAPTURE, EDGE_FALL, $urandom_range(0, 65535));
      end else begin
        if ($urandom_range(0, 3) == 0)
          send_item(ACTION_CAPTURE, EDGE_RISE, $urandom_range(0, 65535));
        send_item(ACTION_CAPTURE, EDGE_FALL, t0 + on_time);
        if ($urandom_range(0, 3) == 0)
          send_item(ACTION_CAPTURE, EDGE_FALL, $urandom_range(0, 65535));
      end
      send_item(ACTION_CAPTURE, EDGE_RISE, t0 + span);
    end else if (kind == 7) begin
      send_item(ACTION_CAPTURE, EDGE_RISE, $urandom_range(0, 65535));
      if (cur_mode == MODE_DUTY)
        send_item(ACTION_CAPTURE, EDGE_FALL, $urandom_range(0, 65535));
      send_item(ACTION_CAPTURE, EDGE_RISE, $urandom_range(0, 65535));
    end else if (kind == 8) begin
      send_item(ACTION_CAPTURE, EDGE_RISE, t0);
      send_item(ACTION_START, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535));
    end
  endtask

  initial begin
    int phase_idx;
    int phase_start;
    logic mode;
    int hz;
    int presc;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Frequency mode at reset settings: start, wrong edge, extremes, saturation, bad times
    send_item(ACTION_START, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_FALL, 65535);
    send_item(ACTION_CAPTURE, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 65535);
    send_item(ACTION_CAPTURE, EDGE_RISE, 100);
    send_item(ACTION_CAPTURE, EDGE_RISE, 101);
    send_item(ACTION_CAPTURE, EDGE_RISE, 1000);
    send_item(ACTION_CAPTURE, EDGE_RISE, 999);
    send_item(ACTION_CAPTURE, EDGE_RISE, 10);
    send_item(ACTION_START, EDGE_FALL, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 20);
    send_item(ACTION_CAPTURE, EDGE_RISE, 21);

    // Duty mode: ignored rise mid-sequence, near-full on time, bad closing time
    apply_setting(MODE_DUTY, int'(CLOCK_HZ_RESET), int'(PRESCALER_RESET));
    send_item(ACTION_CAPTURE, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 5);
    send_item(ACTION_CAPTURE, EDGE_FALL, 25);
    send_item(ACTION_CAPTURE, EDGE_RISE, 100);
    send_item(ACTION_CAPTURE, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_FALL, 65534);
    send_item(ACTION_CAPTURE, EDGE_RISE, 65535);
    send_item(ACTION_CAPTURE, EDGE_RISE, 10);
    send_item(ACTION_CAPTURE, EDGE_FALL, 20);
    send_item(ACTION_CAPTURE, EDGE_RISE, 20);

    // Leave duty mode waiting for its closing rise, then close it in frequency mode
    send_item(ACTION_CAPTURE, EDGE_RISE, 100);
    send_item(ACTION_CAPTURE, EDGE_FALL, 200);
    apply_setting(MODE_FREQUENCY, int'(CLOCK_HZ_RESET), int'(PRESCALER_RESET));
    send_item(ACTION_CAPTURE, EDGE_RISE, 300);

    // Prescaler of zero at the top test clock, then the slowest clock with a prescaler of 1024
    apply_setting(MODE_FREQUENCY, 100000000, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 65535);
    apply_setting(MODE_FREQUENCY, 1, 1024);
    send_item(ACTION_CAPTURE, EDGE_RISE, 0);
    send_item(ACTION_CAPTURE, EDGE_RISE, 1);

    // Random phases, each under its own register setting; the last one runs without idling
    for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      mode = (phase_idx == PHASE_COUNT - 1) ? logic'($urandom_range(0, 1)) : phase_idx[0];
      hz = (phase_idx == 0) ? 100000000 :
           (phase_idx == 2) ? 1 : $urandom_range(1, 100000000);
      presc = (phase_idx == 0) ? 1 :
              (phase_idx == 2) ? 1024 : $urandom_range(1, 1024);
      apply_setting(mode, hz, presc);
      quiet = (phase_idx == PHASE_COUNT - 1);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
    end

    settle();
    $display("Covered %0d capture transactions under %0d register settings, both modes.",
             items_sent, settings_used);
    $display("Compared %0d readings, %0d mismatches.", readings_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Bound the run well past the slowest correct pass
  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
sv/cfdm_pkg.sv
sv/cfdm_divider.sv
sv/capture_frequency_duty_meter.sv
sv/cfdm_checker.sv
dv/meter_checker.sv
dv/tb_top.sv
